// File: hdl/brf_pkg.sv
package brf_pkg;

   // Buffer geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = 7;
   localparam int BYTE_W = 8;
   localparam int OP_W   = 2;

   localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'd10;

   // Request op codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_COUNT = 2'd1;
   localparam logic [OP_W-1:0] OP_LINE  = 2'd2;

   // Commands handed from the front end to the execution side
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_COUNT = 2'd1,
      CMD_LINE  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [BYTE_W-1:0]  data;
      logic [FILL_W-1:0]  count;
   } cmd_type;

   // Ring pointer advance with wrap
   function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] r;
      if (p == ADDR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ADDR_W'(1);
      end
      return r;
   endfunction

endpackage

// File: hdl/brf_if.sv
interface brf_req_if;
   import brf_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [BYTE_W-1:0]  data_in;
   logic [FILL_W-1:0]  read_count;
   modport source (output valid, op, data_in, read_count, input ready);
   modport sink (input valid, op, data_in, read_count, output ready);
endinterface

interface brf_rsp_if;
   import brf_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_out;
   logic               ok;
   logic               last;
   logic [FILL_W-1:0]  fill_level;
   modport source (output valid, data_out, ok, last, fill_level, input ready);
   modport sink (input valid, data_out, ok, last, fill_level, output ready);
endinterface

interface brf_csr_if;
   import brf_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  line_end;
   modport source (output valid, line_end, input ready);
   modport sink (input valid, line_end, output ready);
endinterface

// File: hdl/byte_ring_fifo_line_read.sv
// Byte ring FIFO of 64 entries with write, counted read and line read. A write
// gives one transaction on rsp_chan (ok low when full); a counted read gives
// one transaction per popped byte, or a single failure when too few bytes are
// stored; a line read pops through the first byte equal to line_end (reset
// 10), or everything stored, and gives nothing on an empty buffer. Unused op
// and zero-count reads are taken and dropped. Requests are decoded into a
// two-entry command queue, so req_chan keeps accepting while a read drains.
// A taken request is registered in the decode stage, then in the queue, before
// it reaches the execution side. A write or failure is answered as it is
// dequeued; a read is dequeued, then fetches its first byte through the
// registered store read, then emits one byte per cycle while rsp_chan is
// ready. The user must write line_end through csr_chan only while the block
// is idle; the block itself does not enforce it.
module byte_ring_fifo_line_read
   import brf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   brf_req_if.sink      req_chan,
   brf_rsp_if.source    rsp_chan,
   brf_csr_if.sink      csr_chan
);

   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_full;
   logic    q_pop;
   cmd_type q_pop_cmd;
   logic    q_empty;

   brf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   brf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .empty    (q_empty)
   );

   brf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_cmd    (q_pop_cmd),
      .q_pop    (q_pop),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: hdl/brf_front.sv
module brf_front
   import brf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   brf_req_if.sink       req_chan,
   input  logic          q_full,
   output logic          q_push,
   output cmd_type       q_cmd
);

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_cmd_ff, stage_cmd_in;
   logic    accept;
   logic    keep;
   cmd_type dec_cmd;

   // Stage frees up when empty or when its command moves into the queue
   assign req_chan.ready = !stage_valid_ff || !q_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign q_push = stage_valid_ff && !q_full;
   assign q_cmd  = stage_cmd_ff;

   // Classify: unused op and zero-length counted read produce nothing
   always_comb begin
      keep = 1'b0;
      dec_cmd.kind  = CMD_WRITE;
      dec_cmd.data  = req_chan.data_in;
      dec_cmd.count = req_chan.read_count;
      unique case (req_chan.op)
         OP_WRITE: begin
            keep = 1'b1;
            dec_cmd.kind = CMD_WRITE;
         end
         OP_COUNT: begin
            keep = (req_chan.read_count != '0);
            dec_cmd.kind = CMD_COUNT;
         end
         OP_LINE: begin
            keep = 1'b1;
            dec_cmd.kind = CMD_LINE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff && !q_push;
      stage_cmd_in   = stage_cmd_ff;
      if (accept && keep) begin
         stage_valid_in = 1'b1;
         stage_cmd_in   = dec_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

// File: hdl/brf_cmd_queue.sv
module brf_cmd_queue
   import brf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   // Two-entry command queue between front and back
   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  used_ff, used_in;

   assign full    = (used_ff == 2'd2);
   assign empty   = (used_ff == 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      used_in   = used_ff;
      if (push && !pop) begin
         used_in = used_ff + 2'd1;
      end else if (pop && !push) begin
         used_in = used_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/brf_back.sv
module brf_back
   import brf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  cmd_type       q_cmd,
   output logic          q_pop,
   brf_csr_if.sink       csr_chan,
   brf_rsp_if.source     rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Byte store, written and read in clocked blocks
   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              mem_we;
   logic              fetch;

   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] fetch_ptr_ff, fetch_ptr_in;
   logic [FILL_W-1:0] fetch_left_ff, fetch_left_in;
   logic [FILL_W-1:0] left_ff, left_in;
   logic              line_mode_ff, line_mode_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] line_end_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;

   logic can_load;
   logic deliver;
   logic last_now;

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.data_out   = rsp_data_ff;
   assign rsp_chan.ok         = rsp_ok_ff;
   assign rsp_chan.last       = rsp_last_ff;
   assign rsp_chan.fill_level = rsp_fill_ff;

   // Output register can take a new transaction this cycle
   assign can_load = !rsp_valid_ff || rsp_chan.ready;

   // Pop run: fetched byte goes out, next byte is prefetched alongside
   assign last_now = (left_ff == FILL_W'(1)) ||
                     (line_mode_ff && (rd_data_ff == line_end_ff));
   assign deliver  = (state_ff == ST_RUN) && pend_ff && can_load;
   assign fetch    = (state_ff == ST_RUN) && (fetch_left_ff != '0) &&
                     (!pend_ff || deliver) && !(deliver && last_now);

   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      fetch_ptr_in  = fetch_ptr_ff;
      fetch_left_in = fetch_left_ff;
      left_in       = left_ff;
      line_mode_in  = line_mode_ff;
      pend_in       = pend_ff;
      mem_we        = 1'b0;
      q_pop         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fill_in   = rsp_fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && can_load) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  CMD_WRITE: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (count_ff == FILL_W'(DEPTH)) begin
                        rsp_ok_in   = 1'b0;
                        rsp_fill_in = count_ff;
                     end else begin
                        mem_we      = 1'b1;
                        wr_ptr_in   = ptr_next(wr_ptr_ff);
                        count_in    = count_ff + FILL_W'(1);
                        rsp_ok_in   = 1'b1;
                        rsp_fill_in = count_ff + FILL_W'(1);
                     end
                  end
                  CMD_COUNT: begin
                     if (q_cmd.count > count_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_ok_in    = 1'b0;
                        rsp_last_in  = 1'b1;
                        rsp_fill_in  = count_ff;
                     end else begin
                        state_in      = ST_RUN;
                        fetch_ptr_in  = rd_ptr_ff;
                        fetch_left_in = q_cmd.count;
                        left_in       = q_cmd.count;
                        line_mode_in  = 1'b0;
                        pend_in       = 1'b0;
                     end
                  end
                  CMD_LINE: begin
                     // empty buffer: line read yields nothing
                     if (count_ff != '0) begin
                        state_in      = ST_RUN;
                        fetch_ptr_in  = rd_ptr_ff;
                        fetch_left_in = count_ff;
                        left_in       = count_ff;
                        line_mode_in  = 1'b1;
                        pend_in       = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (deliver) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data_ff;
               rsp_ok_in    = 1'b1;
               rsp_last_in  = last_now;
               rsp_fill_in  = count_ff - FILL_W'(1);
               rd_ptr_in    = ptr_next(rd_ptr_ff);
               count_in     = count_ff - FILL_W'(1);
               left_in      = left_ff - FILL_W'(1);
               pend_in      = 1'b0;
               if (last_now) begin
                  state_in = ST_IDLE;
               end
            end
            if (fetch) begin
               fetch_ptr_in  = ptr_next(fetch_ptr_ff);
               fetch_left_in = fetch_left_ff - FILL_W'(1);
               pend_in       = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store access
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= q_cmd.data;
      end
      if (fetch) begin
         rd_data_ff <= mem[fetch_ptr_ff];
      end
   end

   // Control and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_end_ff  <= LINE_END_RESET;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            line_end_ff <= csr_chan.line_end;
         end
      end
      fetch_ptr_ff  <= fetch_ptr_in;
      fetch_left_ff <= fetch_left_in;
      left_ff       <= left_in;
      line_mode_ff  <= line_mode_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

endmodule

// File: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import brf_pkg::*;

   // op value that the block takes and drops
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // selects the live ring copy or the one the generator runs ahead with
   localparam int LIVE = 0;
   localparam int GEN  = 1;

   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 100;
   localparam int PHASE_ITEMS   = 30;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data;
      logic [FILL_W-1:0] count;
      logic              hold;    // wait for all results before sending
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              ok;
      logic              last;
      logic [FILL_W-1:0] fill;
   } rsp_item_type;

   logic clock;
   logic reset;

   brf_req_if req_chan ();
   brf_rsp_if rsp_chan ();
   brf_csr_if csr_chan ();

   byte_ring_fifo_line_read uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // ring copies: index LIVE tracks accepted traffic, GEN is for generation
   logic [BYTE_W-1:0] rb_mem  [2][DEPTH];
   logic [ADDR_W-1:0] rb_wr   [2];
   logic [ADDR_W-1:0] rb_rd   [2];
   logic [FILL_W-1:0] rb_fill [2];
   logic [BYTE_W-1:0] rb_stop [2];

   req_item_type req_backlog [$];
   rsp_item_type rsp_expected [$];
   req_item_type cur_req;
   rsp_item_type rsp_head;

   int err_cnt    = 0;
   int n_queued   = 0;
   int n_accepted = 0;
   int send_idle  = 0;
   int recv_idle  = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [ADDR_W-1:0] ring_adv(input logic [ADDR_W-1:0] p);
      return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic void emit_rsp(input int sel, input bit record,
                                    input logic [BYTE_W-1:0] data,
                                    input logic ok, input logic last);
      if (record) begin
         rsp_expected.push_back('{data: data, ok: ok, last: last, fill: rb_fill[sel]});
      end
   endfunction

   function automatic int ring_pop(input int sel, input bit record, input int n);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < n; i++) begin
         b = rb_mem[sel][rb_rd[sel]];
         rb_rd[sel] = ring_adv(rb_rd[sel]);
         rb_fill[sel] = rb_fill[sel] - 1'b1;
         emit_rsp(sel, record, b, 1'b1, (i + 1 == n));
      end
      return n;
   endfunction

   // one operation on a ring copy; returns the number of results it causes
   function automatic int ring_step(input int sel, input req_item_type it,
                                    input bit record);
      int n;
      logic [ADDR_W-1:0] p;
      n = 0;
      case (it.op)
         OP_WRITE: begin
            if (rb_fill[sel] >= DEPTH) begin
               emit_rsp(sel, record, '0, 1'b0, 1'b1);
            end else begin
               rb_mem[sel][rb_wr[sel]] = it.data;
               rb_wr[sel] = ring_adv(rb_wr[sel]);
               rb_fill[sel] = rb_fill[sel] + 1'b1;
               emit_rsp(sel, record, '0, 1'b1, 1'b1);
            end
            n = 1;
         end
         OP_COUNT: begin
            if (it.count == 0) begin
               n = 0;
            end else if (it.count > rb_fill[sel]) begin
               emit_rsp(sel, record, '0, 1'b0, 1'b1);
               n = 1;
            end else begin
               n = ring_pop(sel, record, int'(it.count));
            end
         end
         OP_LINE: begin
            // scan up to and including the first stop byte
            p = rb_rd[sel];
            while (n < int'(rb_fill[sel])) begin
               n++;
               if (rb_mem[sel][p] == rb_stop[sel]) break;
               p = ring_adv(p);
            end
            n = ring_pop(sel, record, n);
         end
         default: n = 0;
      endcase
      return n;
   endfunction

   // queue an item for the driver and run it on the generator copy
   function automatic int queue_req(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                                    input logic [FILL_W-1:0] count, input bit hold);
      req_item_type it;
      it = '{op: op, data: data, count: count, hold: hold};
      req_backlog.push_back(it);
      n_queued++;
      return ring_step(GEN, it, 1'b0);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      int r;
      r = $urandom_range(99);
      if (r < 20) return rb_stop[GEN];
      if (r < 30) return 8'h00;
      if (r < 40) return 8'hFF;
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic void check_field(input string name, input logic [BYTE_W-1:0] expv,
                                       input logic [BYTE_W-1:0] actv);
      if (actv !== expv) begin
         err_cnt++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, expv, actv);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            void'(ring_step(LIVE, cur_req, 1'b1));
            n_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle &&
                !(req_backlog[0].hold && rsp_expected.size() != 0)) begin
               cur_req = req_backlog.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.op         <= cur_req.op;
               req_chan.data_in    <= cur_req.data;
               req_chan.read_count <= cur_req.count;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (rsp_expected.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected transaction, expected none actual %0h %0b %0b %0d",
                        $realtime, rsp_chan.data_out, rsp_chan.ok, rsp_chan.last,
                        rsp_chan.fill_level);
            end else begin
               rsp_head = rsp_expected.pop_front();
               check_field("data_out", rsp_head.data, rsp_chan.data_out);
               check_field("ok", 8'(rsp_head.ok), 8'(rsp_chan.ok));
               check_field("last", 8'(rsp_head.last), 8'(rsp_chan.last));
               check_field("fill_level", 8'(rsp_head.fill), 8'(rsp_chan.fill_level));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // wait until every item is taken and every result is back, then settle
   task automatic wait_idle();
      do @(posedge clock);
      while (n_accepted != n_queued || rsp_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_end(input logic [BYTE_W-1:0] v);
      @(posedge clock);
      csr_chan.valid    <= 1'b1;
      csr_chan.line_end <= v;
      do @(posedge clock);
      while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      rb_stop[LIVE] = v;
   endtask

   function automatic void sync_gen_copy();
      for (int i = 0; i < DEPTH; i++) rb_mem[GEN][i] = rb_mem[LIVE][i];
      rb_wr[GEN]   = rb_wr[LIVE];
      rb_rd[GEN]   = rb_rd[LIVE];
      rb_fill[GEN] = rb_fill[LIVE];
      rb_stop[GEN] = rb_stop[LIVE];
   endfunction

   // edge cases first, at the reset line end
   function automatic void gen_directed();
      void'(queue_req(OP_LINE, 8'hA5, 7'd0, 1'b0));     // line read on empty buffer
      void'(queue_req(OP_COUNT, 8'h00, 7'd1, 1'b0));    // too few stored
      void'(queue_req(OP_COUNT, 8'hFF, 7'd0, 1'b0));    // zero-byte read
      void'(queue_req(OP_UNUSED, 8'hFF, 7'h7F, 1'b0));  // dropped op
      void'(queue_req(OP_COUNT, 8'h5A, 7'h7F, 1'b0));
      void'(queue_req(OP_WRITE, 8'h00, 7'h7F, 1'b0));
      void'(queue_req(OP_WRITE, 8'hFF, 7'h00, 1'b0));
      void'(queue_req(OP_WRITE, LINE_END_RESET, 7'h40, 1'b0));
      void'(queue_req(OP_WRITE, 8'h41, 7'h3F, 1'b0));
      void'(queue_req(OP_LINE, 8'h00, 7'h00, 1'b0));
      void'(queue_req(OP_COUNT, 8'h00, 7'd1, 1'b0));
      void'(queue_req(OP_WRITE, 8'h33, 7'h00, 1'b1));   // sender drains first
      void'(queue_req(OP_WRITE, 8'h34, 7'h00, 1'b0));
      void'(queue_req(OP_LINE, 8'hFF, 7'h7F, 1'b0));    // no stop byte stored
      void'(queue_req(OP_WRITE, LINE_END_RESET, 7'h00, 1'b0));
      void'(queue_req(OP_LINE, 8'h00, 7'h00, 1'b0));    // stop byte at the head
      void'(queue_req(OP_WRITE, 8'h55, 7'h00, 1'b0));
      void'(queue_req(OP_WRITE, 8'h66, 7'h00, 1'b0));
      void'(queue_req(OP_COUNT, 8'h00, 7'd3, 1'b0));
      void'(queue_req(OP_COUNT, 8'h00, 7'd2, 1'b0));
      void'(queue_req(OP_COUNT, 8'h00, 7'd64, 1'b0));
   endfunction

   // random traffic, mostly well-formed write/read mixes; target counts items
   function automatic void gen_random(input int target, input bit start_full);
      int base;
      int r;
      int k;
      int cnt;
      bit hold_next;
      base = n_queued;
      hold_next = 1'b0;
      if (start_full) begin
         while (rb_fill[GEN] < DEPTH)
            void'(queue_req(OP_WRITE, rand_byte(), FILL_W'($urandom_range(127)), 1'b0));
         void'(queue_req(OP_WRITE, rand_byte(), 7'h7F, 1'b0));   // full
         void'(queue_req(OP_WRITE, rand_byte(), 7'h00, 1'b0));
         void'(queue_req(OP_COUNT, rand_byte(), 7'd65, 1'b0));
         if ($urandom_range(1)) void'(queue_req(OP_COUNT, rand_byte(), 7'd64, 1'b0));
      end
      while (n_queued - base < target) begin
         r = $urandom_range(99);
         if (r < 40) begin
            k = (r < 35) ? $urandom_range(12, 1) : $urandom_range(4, 1);
            for (int i = 0; i < k; i++) begin
               void'(queue_req(OP_WRITE, rand_byte(), FILL_W'($urandom_range(127)),
                               hold_next));
               hold_next = 1'b0;
            end
         end else if (r < 60) begin
            if (rb_fill[GEN] == 0) cnt = 1;
            else if ($urandom_range(3) == 0) cnt = rb_fill[GEN];
            else cnt = $urandom_range(int'(rb_fill[GEN]), 1);
            void'(queue_req(OP_COUNT, BYTE_W'($urandom_range(255)), FILL_W'(cnt), hold_next));
            hold_next = 1'b0;
         end else if (r < 82) begin
            void'(queue_req(OP_LINE, BYTE_W'($urandom_range(255)),
                            FILL_W'($urandom_range(127)), hold_next));
            hold_next = 1'b0;
         end else if (r < 94) begin
            case ($urandom_range(3))
               0: void'(queue_req(OP_UNUSED, BYTE_W'($urandom_range(255)),
                                  FILL_W'($urandom_range(127)), hold_next));
               1: void'(queue_req(OP_COUNT, BYTE_W'($urandom_range(255)), 7'd0, hold_next));
               2: void'(queue_req(OP_COUNT, BYTE_W'($urandom_range(255)),
                                  FILL_W'($urandom_range(127, int'(rb_fill[GEN]) + 1)),
                                  hold_next));
               default: void'(queue_req(OP_LINE, BYTE_W'($urandom_range(255)),
                                        FILL_W'($urandom_range(127)), hold_next));
            endcase
            hold_next = 1'b0;
         end else begin
            hold_next = 1'b1;
         end
      end
   endfunction

   // stimulus sequencing
   initial begin
      logic [BYTE_W-1:0] stops [9];
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_WRITE;
      req_chan.data_in    = '0;
      req_chan.read_count = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.line_end   = '0;
      for (int i = 0; i < DEPTH; i++) rb_mem[LIVE][i] = '0;
      rb_wr[LIVE]   = '0;
      rb_rd[LIVE]   = '0;
      rb_fill[LIVE] = '0;
      rb_stop[LIVE] = LINE_END_RESET;
      stops = '{LINE_END_RESET, 8'h00, 8'hFF, BYTE_W'($urandom_range(255)), 8'h0A,
                BYTE_W'($urandom_range(255)), 8'h80, BYTE_W'($urandom_range(255)), 8'hFF};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 9; ph++) begin
         // idle profiles: sender light then receiver light then none
         if (ph < 3) begin
            send_idle = 11;
            recv_idle = 68;
         end else if (ph < 6) begin
            send_idle = 68;
            recv_idle = 11;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (ph > 0) begin
            wait_idle();
            write_line_end(stops[ph]);
         end
         sync_gen_copy();
         if (ph == 0) gen_directed();
         else gen_random(PHASE_ITEMS, (ph == 2 || ph == 6));
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/brf_pkg.sv
hdl/brf_if.sv
hdl/brf_front.sv
hdl/brf_cmd_queue.sv
hdl/brf_back.sv
hdl/byte_ring_fifo_line_read.sv
sim/tb_top.sv
